>>> design/bbf_pkg.sv
// Shared types and constants for the box blur filter.
package bbf_pkg;

    localparam int CH_W   = 8;
    localparam int SUM_W  = 18;
    localparam int AREA_W = 10;
    localparam int DIV_CW = 5;
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 13;

    localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] REG_X_RADIUS     = 2'd2;
    localparam logic [CFG_IW-1:0] REG_Y_RADIUS     = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_FLUSH,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic div_load;
        logic div_step;
        logic j_adv;
    } cmd_t;

    typedef struct packed {
        logic has_out;
        logic last_tap;
        logic div_last;
        logic j_last;
    } status_t;

endpackage

>>> design/bbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/bbf_ctrl.sv
// Sequencer for the box blur filter: item intake, window sweep, divide, result.
module bbf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             out_ready,
    input  bbf_pkg::status_t status,
    output bbf_pkg::cmd_t    cmd,
    output logic             in_ready,
    output logic             out_valid
);
    import bbf_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.has_out)
                    begin
                        state_next = ST_ACC;
                    end
                end
            end
            ST_ACC:
            begin
                cmd.rd_en = 1'b1;
                if (status.last_tap)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.j_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.j_adv  = 1'b1;
                        state_next = ST_ACC;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/bbf_datapath.sv
// Datapath: registers, frame position, line store, window accumulators, divider.
module bbf_datapath #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_X_RADIUS = 15,
    parameter int MAX_Y_RADIUS = 15
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [bbf_pkg::CFG_IW-1:0]     cfg_index,
    input  logic [bbf_pkg::CFG_DW-1:0]     cfg_data,
    input  logic [7:0]                     in_red,
    input  logic [7:0]                     in_green,
    input  logic [7:0]                     in_blue,
    input  logic [7:0]                     in_alpha,
    input  bbf_pkg::cmd_t                  cmd,
    output bbf_pkg::status_t               status,
    output logic [7:0]                     out_red,
    output logic [7:0]                     out_green,
    output logic [7:0]                     out_blue,
    output logic [7:0]                     out_alpha,
    output logic [9:0]                     out_column,
    output logic [11:0]                    out_row,
    output logic                           last_in_run
);
    import bbf_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int SLOTS = 2 * MAX_Y_RADIUS + 1;
    localparam int SW    = $clog2(SLOTS);
    localparam int XW    = $clog2(2 * MAX_X_RADIUS + 1);
    localparam int DEPTH = SLOTS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    // configuration
    logic [10:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic [3:0]  x_radius_reg;
    logic [3:0]  y_radius_reg;
    logic        cfg_hit;

    assign cfg_hit = cfg_write_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 11'd640;
            image_height_reg <= 13'd480;
            x_radius_reg     <= 4'd1;
            y_radius_reg     <= 4'd1;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[10:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                REG_X_RADIUS:     x_radius_reg     <= cfg_data[3:0];
                REG_Y_RADIUS:     y_radius_reg     <= cfg_data[3:0];
                default:          image_width_reg  <= image_width_reg;
            endcase
        end
    end

    logic [WW-1:0] w_eff;
    logic [12:0]   h_eff;
    logic [3:0]    xr;
    logic [3:0]    yr;
    logic [AREA_W-1:0] area;

    always_comb
    begin
        if (image_width_reg == 11'd0)
        begin
            w_eff = WW'(1);
        end
        else if (int'(image_width_reg) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(image_width_reg);
        end
        if (image_height_reg == 13'd0)
        begin
            h_eff = 13'd1;
        end
        else if (image_height_reg > 13'd4096)
        begin
            h_eff = 13'd4096;
        end
        else
        begin
            h_eff = image_height_reg;
        end
        xr = (int'(x_radius_reg) > MAX_X_RADIUS) ? 4'(MAX_X_RADIUS) : x_radius_reg;
        yr = (int'(y_radius_reg) > MAX_Y_RADIUS) ? 4'(MAX_Y_RADIUS) : y_radius_reg;
    end

    assign area = AREA_W'(({5'd0, xr, 1'b1}) * ({5'd0, yr, 1'b1}));

    // frame position
    logic [CW-1:0] col_reg;
    logic [12:0]   row_reg;
    logic [11:0]   orow_reg;
    logic [SW-1:0] wslot_reg;
    logic          row_end;
    logic          pixel_row;
    logic [CW-1:0] xr_c;
    logic [CW-1:0] jlo;
    logic [CW-1:0] jhi;

    assign xr_c      = CW'(xr);
    assign row_end   = (WW'(col_reg) + WW'(1)) >= w_eff;
    assign pixel_row = row_reg < h_eff;
    assign jlo       = (col_reg >= xr_c) ? col_reg - xr_c : '0;
    assign jhi       = row_end ? col_reg : col_reg - xr_c;
    assign status.has_out = (row_reg >= 13'(yr)) && (row_end || col_reg >= xr_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            orow_reg  <= '0;
            wslot_reg <= '0;
        end
        else if (cfg_hit)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            orow_reg  <= '0;
            wslot_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (row_end)
            begin
                col_reg <= '0;
                if ((row_reg + 13'd1) >= (h_eff + 13'(yr)))
                begin
                    row_reg   <= '0;
                    orow_reg  <= '0;
                    wslot_reg <= '0;
                end
                else
                begin
                    row_reg <= row_reg + 13'd1;
                    if (row_reg >= 13'(yr))
                    begin
                        orow_reg <= orow_reg + 12'd1;
                    end
                    if (wslot_reg == SW'({yr, 1'b0}))
                    begin
                        wslot_reg <= '0;
                    end
                    else
                    begin
                        wslot_reg <= wslot_reg + SW'(1);
                    end
                end
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // item context
    logic [12:0]   r_l_reg;
    logic [11:0]   o_l_reg;
    logic [SW-1:0] ws_l_reg;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] jhi_reg;
    logic [SW-1:0] iy_reg;
    logic [XW-1:0] ix_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            r_l_reg  <= row_reg;
            o_l_reg  <= orow_reg;
            ws_l_reg <= wslot_reg;
            j_reg    <= jlo;
            jhi_reg  <= jhi;
        end
        else if (cmd.j_adv)
        begin
            j_reg <= j_reg + CW'(1);
        end
    end

    assign status.last_tap = (iy_reg == SW'({yr, 1'b0})) && (ix_reg == XW'({xr, 1'b0}));
    assign status.j_last   = (j_reg == jhi_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.accept || cmd.j_adv)
        begin
            iy_reg <= '0;
            ix_reg <= '0;
        end
        else if (cmd.rd_en)
        begin
            if (ix_reg == XW'({xr, 1'b0}))
            begin
                ix_reg <= '0;
                iy_reg <= iy_reg + SW'(1);
            end
            else
            begin
                ix_reg <= ix_reg + XW'(1);
            end
        end
    end

    // tap address: rows clamp to the frame, slot follows the row ring
    logic signed [14:0] kk;
    logic [12:0]        k_cl;
    logic [12:0]        d_full;
    logic signed [SW+1:0] slot_s;
    logic [SW-1:0]      rslot;
    logic signed [CW+1:0] cc;
    logic [CW-1:0]      rcol;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;

    always_comb
    begin
        kk = $signed({2'b00, r_l_reg}) - $signed({10'd0, yr, 1'b0})
             + $signed({{(15-SW){1'b0}}, iy_reg});
        if (kk < 0)
        begin
            k_cl = '0;
        end
        else if (kk > $signed({2'b00, h_eff - 13'd1}))
        begin
            k_cl = h_eff - 13'd1;
        end
        else
        begin
            k_cl = kk[12:0];
        end
        d_full = r_l_reg - k_cl;
        slot_s = $signed({2'b00, ws_l_reg}) - $signed({2'b00, d_full[SW-1:0]});
        if (slot_s < 0)
        begin
            slot_s = slot_s + $signed((SW+2)'({yr, 1'b1}));
        end
        rslot = slot_s[SW-1:0];
        cc = $signed({2'b00, j_reg}) - $signed({2'b00, xr_c})
             + $signed((CW+2)'(ix_reg));
        if (cc < 0)
        begin
            rcol = '0;
        end
        else if (cc > $signed((CW+2)'(w_eff - WW'(1))))
        begin
            rcol = CW'(w_eff - WW'(1));
        end
        else
        begin
            rcol = cc[CW-1:0];
        end
    end

    assign raddr = AW'(rslot * MAX_WIDTH) + AW'(rcol);
    assign waddr = AW'(wslot_reg * MAX_WIDTH) + AW'(col_reg);

    logic [31:0] rdata;

    bbf_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (cmd.accept && pixel_row),
        .waddr (waddr),
        .wdata ({in_alpha, in_blue, in_green, in_red}),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    // accumulate and divide
    logic                rd_valid_reg;
    logic [SUM_W-1:0]    sum_reg [4];
    logic [SUM_W-1:0]    quo_reg [4];
    logic [AREA_W-1:0]   rem_reg [4];
    logic [DIV_CW-1:0]   dcnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
        end
    end

    assign status.div_last = (dcnt_reg == DIV_CW'(SUM_W - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + DIV_CW'(1);
        end
    end

    for (genvar ch = 0; ch < 4; ch++)
    begin : g_ch
        logic [AREA_W:0] trial;

        assign trial = {rem_reg[ch], quo_reg[ch][SUM_W-1]};

        always_ff @(posedge clk)
        begin
            if (cmd.accept || cmd.j_adv)
            begin
                sum_reg[ch] <= '0;
            end
            else if (rd_valid_reg)
            begin
                sum_reg[ch] <= sum_reg[ch] + SUM_W'(rdata[ch*CH_W +: CH_W]);
            end
            if (cmd.div_load)
            begin
                quo_reg[ch] <= sum_reg[ch];
                rem_reg[ch] <= '0;
            end
            else if (cmd.div_step)
            begin
                if (trial >= {1'b0, area})
                begin
                    rem_reg[ch] <= AREA_W'(trial - {1'b0, area});
                    quo_reg[ch] <= {quo_reg[ch][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[ch] <= trial[AREA_W-1:0];
                    quo_reg[ch] <= {quo_reg[ch][SUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_red     = quo_reg[0][CH_W-1:0];
    assign out_green   = quo_reg[1][CH_W-1:0];
    assign out_blue    = quo_reg[2][CH_W-1:0];
    assign out_alpha   = quo_reg[3][CH_W-1:0];
    assign out_column  = 10'(j_reg);
    assign out_row     = o_l_reg;
    assign last_in_run = status.j_last;

endmodule

>>> design/box_blur_filter_core.sv
// Top level of the box blur filter core.
// Streams RGBA pixels in raster order and returns box-blurred pixels with
// edge clamping; output lags by y_radius rows and x_radius columns, and
// y_radius rows of drain items flush the bottom rows. One item is handled
// at a time: an item with no result needs nothing beyond its intake; each result takes
// (2*x_radius+1)*(2*y_radius+1) line store reads (one read port, one per
// cycle) followed by flush, load, a serial divide and output.
// The right-edge item of a row gives up to x_radius+1 results in one run.
// Any register write restarts the frame position.
module box_blur_filter_core #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_X_RADIUS = 15,
    parameter int MAX_Y_RADIUS = 15
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [bbf_pkg::CFG_IW-1:0] cfg_index,
    input  logic [bbf_pkg::CFG_DW-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       command,
    input  logic [7:0]                 in_red,
    input  logic [7:0]                 in_green,
    input  logic [7:0]                 in_blue,
    input  logic [7:0]                 in_alpha,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 out_red,
    output logic [7:0]                 out_green,
    output logic [7:0]                 out_blue,
    output logic [7:0]                 out_alpha,
    output logic [9:0]                 out_column,
    output logic [11:0]                out_row,
    output logic                       last_in_run
);
    import bbf_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    unused_command;

    // item kind follows from the frame position alone
    assign unused_command = command;

    bbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    bbf_datapath #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_X_RADIUS (MAX_X_RADIUS),
        .MAX_Y_RADIUS (MAX_Y_RADIUS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_red       (in_red),
        .in_green     (in_green),
        .in_blue      (in_blue),
        .in_alpha     (in_alpha),
        .cmd          (cmd),
        .status       (status),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_alpha    (out_alpha),
        .out_column   (out_column),
        .out_row      (out_row),
        .last_in_run  (last_in_run)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("intake and result offered together");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid)
        else $error("result shown right after intake");

    a_run_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_in_run) |=> in_ready)
        else $error("not idle after last result of a run");

endmodule
